### design/rfp_pkg.sv
// Shared constants, types and helpers for the rangefinder frame parser.
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned DistW = 20;
  localparam int unsigned PosW  = 4;

  localparam logic [ByteW-1:0] SyncByte  = 8'h80;
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;
  localparam logic [ByteW-1:0] AsciiDot  = 8'h2E;

  localparam logic [PosW-1:0] PosHunt  = 4'd0;
  localparam logic [PosW-1:0] PosFirst = 4'd1;
  localparam logic [PosW-1:0] PosDot   = 4'd6;
  localparam logic [PosW-1:0] PosCheck = 4'd10;
  localparam logic [PosW-1:0] FrameLen = 4'd11;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic [PosW-1:0]  pos_t;

  // Outcome of one consumed byte.
  typedef struct packed {
    logic  hit;
    dist_t dist_val;
  } result_t;

  function automatic logic is_digit(input byte_t b);
    return (b >= AsciiZero) && (b <= AsciiNine);
  endfunction

  function automatic logic is_digit_slot(input pos_t p);
    return ((p >= 4'd3) && (p <= 4'd5)) || ((p >= 4'd7) && (p <= 4'd9));
  endfunction

endpackage

`default_nettype wire

### design/rfp_rx_if.sv
// Valid/ready channel carrying received serial bytes.
`timescale 1ns / 1ps
`default_nettype none

interface rfp_rx_if;
  logic                     valid;
  logic                     ready;
  logic [rfp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### design/rfp_dist_if.sv
// Valid/ready channel carrying decoded distances.
`timescale 1ns / 1ps
`default_nettype none

interface rfp_dist_if;
  logic                      valid;
  logic                      ready;
  logic [rfp_pkg::DistW-1:0] distance_thousandths;

  modport source (output valid, output distance_thousandths, input ready);
  modport sink   (input valid, input distance_thousandths, output ready);
endinterface

`default_nettype wire

### design/rfp_frame_core.sv
// Frame tracker: sync hunt, checksum, digit and dot checks, digit accumulation.
`timescale 1ns / 1ps
`default_nettype none

module rfp_frame_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire rfp_pkg::byte_t   byte_i,
  output rfp_pkg::result_t      res_o
);
  import rfp_pkg::*;

  pos_t  pos_q, pos_d;
  byte_t sum_q, sum_d;
  dist_t digit_q, digit_d;
  logic  good_q, good_d;

  logic [DistW+3:0] times_ten;
  byte_t            expect_sum;
  logic [3:0]       digit_off;

  assign times_ten  = {1'b0, digit_q, 3'b000} + {3'b000, digit_q, 1'b0};
  assign expect_sum = 8'd0 - sum_q;
  assign digit_off  = byte_i[3:0] - AsciiZero[3:0];

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    digit_d  = digit_q;
    good_d   = good_q;
    res_o    = '0;
    res_o.dist_val = digit_q;
    if (step_i) begin
      if ((pos_q == PosHunt) || (pos_q >= FrameLen)) begin
        if (byte_i == SyncByte) begin
          pos_d   = PosFirst;
          sum_d   = byte_i;
          digit_d = '0;
          good_d  = 1'b1;
        end else begin
          pos_d = PosHunt;
        end
      end else if (pos_q == PosCheck) begin
        // Checksum byte closes the frame either way.
        pos_d     = PosHunt;
        res_o.hit = (byte_i == expect_sum) && good_q;
      end else begin
        sum_d = sum_q + byte_i;
        if (is_digit_slot(pos_q)) begin
          if (is_digit(byte_i)) begin
            digit_d = DistW'(times_ten + {{DistW{1'b0}}, digit_off});
          end else begin
            good_d = 1'b0;
          end
        end else if ((pos_q == PosDot) && (byte_i != AsciiDot)) begin
          good_d = 1'b0;
        end
        pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosHunt;
      sum_q   <= '0;
      digit_q <= '0;
      good_q  <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      digit_q <= digit_d;
      good_q  <= good_d;
    end
  end

endmodule

`default_nettype wire

### design/rangefinder_frame_parser.sv
// Top level of the rangefinder frame parser: input register, frame core, result register.
//
//   channel  dir  payload                      width
//   rx_i     in   rx_byte                      8
//   dist_o   out  distance_thousandths         20
//
// One byte per cycle sustained while the result side is not stalled: a request
// moves from rx_i into the input register, then through the frame core into
// the result register, which raises result valid after a good checksum byte.
// Reset (async, active low) clears the frame state to hunting and empties
// both registers. A stalled result holds the input register; the input
// register still frees in the same cycle the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module rangefinder_frame_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfp_rx_if.sink    rx_i,
  rfp_dist_if.source dist_o
);
  import rfp_pkg::*;

  logic    in_valid_q;
  byte_t   in_byte_q;
  logic    out_valid_q, out_valid_d;
  dist_t   out_dist_q;
  logic    advance;
  result_t res;

  assign advance    = in_valid_q && (!out_valid_q || dist_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  rfp_frame_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.hit;
    end else if (dist_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on request, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (advance && res.hit) begin
      out_dist_q <= res.dist_val;
    end
  end

  assign dist_o.valid                = out_valid_q;
  assign dist_o.distance_thousandths = out_dist_q;

endmodule

`default_nettype wire

### verif/tb_rangefinder_frame_parser.sv
// Self-checking testbench for the rangefinder frame parser: byte stream in, distances checked.
`timescale 1ns / 1ps

module tb_rangefinder_frame_parser;
  import rfp_pkg::*;

  localparam int unsigned BytesTotal    = 1150;
  localparam int unsigned QuietBytes    = 250;
  localparam int unsigned DrainCycles   = 2000;
  localparam int unsigned MaxDistance   = 999999;
  localparam pos_t        PosFirstDigit = 4'd3;

  typedef byte_t frame_t [FrameLen];

  typedef enum int {
    FlawNone,
    FlawChecksum,
    FlawDot,
    FlawDigit,
    FlawShort
  } flaw_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          stall_on;
  int unsigned err_count;
  int unsigned bytes_sent;

  // Shadow frame state and the distances still owed by the block.
  pos_t  hunt_pos   = PosHunt;
  byte_t frame_sum  = '0;
  dist_t digits_acc = '0;
  logic  fmt_ok     = 1'b1;
  dist_t dist_expected [$];

  rfp_rx_if   rx_ch ();
  rfp_dist_if dist_ch ();

  always #10 clk_i = ~clk_i;

  rangefinder_frame_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .dist_o (dist_ch)
  );

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Advance the shadow parser by one accepted byte.
  task automatic parse_byte(input byte_t b);
    if (hunt_pos == PosHunt || hunt_pos >= FrameLen) begin
      if (b == SyncByte) begin
        hunt_pos   = PosFirst;
        frame_sum  = b;
        digits_acc = '0;
        fmt_ok     = 1'b1;
      end else begin
        hunt_pos = PosHunt;
      end
    end else if (hunt_pos == PosCheck) begin
      hunt_pos = PosHunt;
      if (b == byte_t'(8'd0 - frame_sum) && fmt_ok) begin
        dist_expected.push_back(digits_acc);
      end
    end else begin
      frame_sum = frame_sum + b;
      if (hunt_pos >= PosFirstDigit && hunt_pos != PosDot) begin
        if (b >= AsciiZero && b <= AsciiNine) begin
          digits_acc = dist_t'(digits_acc * 10 + (b - AsciiZero));
        end else begin
          fmt_ok = 1'b0;
        end
      end else if (hunt_pos == PosDot && b != AsciiDot) begin
        fmt_ok = 1'b0;
      end
      hunt_pos = hunt_pos + 1'b1;
    end
  endtask

  // Check results first, then account for the request taken at this edge.
  always @(posedge clk_i) begin : dist_check
    dist_t want;
    if (rst_ni) begin
      if (dist_ch.valid && dist_ch.ready) begin
        if (dist_expected.size() == 0) begin
          log_mismatch($sformatf("unexpected distance %0d", dist_ch.distance_thousandths));
        end else begin
          want = dist_expected.pop_front();
          if (dist_ch.distance_thousandths !== want) begin
            log_mismatch($sformatf("distance %0d, expected %0d",
                                   dist_ch.distance_thousandths, want));
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        parse_byte(rx_ch.rx_byte);
      end
    end
  end

  // Result side: ready with random stall bursts while stall_on is set.
  initial begin : dist_sink
    int unsigned hold;
    hold = 0;
    dist_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        dist_ch.ready <= 1'b0;
        hold--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 8) - 1;
        dist_ch.ready <= 1'b0;
      end else begin
        dist_ch.ready <= 1'b1;
      end
    end
  end

  // Hold valid high across back-to-back bytes; drop it only for an idle burst.
  task automatic send_byte(input byte_t b);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    bytes_sent++;
  endtask

  function automatic frame_t sealed(input frame_t f);
    byte_t sum;
    sum = '0;
    for (int i = 0; i < PosCheck; i++) sum = sum + f[i];
    f[PosCheck] = 8'd0 - sum;
    return f;
  endfunction

  function automatic frame_t make_frame(input int unsigned dist_val);
    frame_t      f;
    int unsigned rest;
    rest = dist_val;
    f[0] = SyncByte;
    f[1] = byte_t'($urandom);
    f[2] = byte_t'($urandom);
    for (int i = 9; i >= PosFirstDigit; i--) begin
      if (i != PosDot) begin
        f[i] = AsciiZero + byte_t'(rest % 10);
        rest = rest / 10;
      end
    end
    f[PosDot] = AsciiDot;
    return sealed(f);
  endfunction

  function automatic byte_t pick_non_digit();
    if ($urandom_range(0, 1) == 0) return byte_t'($urandom_range(0, AsciiZero - 1));
    return byte_t'($urandom_range(AsciiNine + 1, 255));
  endfunction

  task automatic send_frame(input frame_t f, input int unsigned len);
    for (int i = 0; i < len; i++) send_byte(f[i]);
  endtask

  task automatic test_directed_frames();
    frame_t f;
    // Line noise while hunting, including a stray dot.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(AsciiDot);
    // Zero distance with sync bytes as frame data.
    f = make_frame(0);
    f[1] = SyncByte;
    f[2] = SyncByte;
    send_frame(sealed(f), FrameLen);
    f = make_frame(MaxDistance);
    f[1] = 8'hFF;
    f[2] = 8'h00;
    send_frame(sealed(f), FrameLen);
    // Bad checksum.
    f = make_frame(123456);
    f[PosCheck] = f[PosCheck] ^ 8'h01;
    send_frame(f, FrameLen);
    // Characters just outside the digit range, checksum kept good.
    f = make_frame(654321);
    f[PosFirstDigit] = AsciiNine + 1'b1;
    send_frame(sealed(f), FrameLen);
    f = make_frame(777777);
    f[9] = AsciiZero - 1'b1;
    send_frame(sealed(f), FrameLen);
    // Wrong separator.
    f = make_frame(424242);
    f[PosDot] = 8'h2D;
    send_frame(sealed(f), FrameLen);
    // Recover on the next good frame.
    send_frame(make_frame(500250), FrameLen);
  endtask

  task automatic test_line_noise(input int unsigned count);
    byte_t b;
    for (int n = 0; n < count; n++) begin
      b = byte_t'($urandom);
      send_byte(b);
    end
  endtask

  task automatic test_random_frames(input int unsigned target);
    frame_t      f;
    flaw_e       flaw;
    int unsigned dist_val;
    int unsigned pick;
    byte_t       b;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) dist_val = 0;
      else if (pick == 1) dist_val = MaxDistance;
      else dist_val = $urandom_range(0, MaxDistance);
      f = make_frame(dist_val);
      pick = $urandom_range(0, 19);
      if (pick < 13) flaw = FlawNone;
      else if (pick < 15) flaw = FlawChecksum;
      else if (pick < 17) flaw = FlawDigit;
      else if (pick < 19) flaw = FlawDot;
      else flaw = FlawShort;
      case (flaw)
        FlawChecksum: begin
          f[PosCheck] = f[PosCheck] ^ byte_t'($urandom_range(1, 255));
        end
        FlawDigit: begin
          pick = $urandom_range(0, 5);
          pick = (pick < 3) ? pick + PosFirstDigit : pick + PosDot - 2;
          f[pick] = pick_non_digit();
          f = sealed(f);
        end
        FlawDot: begin
          do f[PosDot] = byte_t'($urandom); while (f[PosDot] == AsciiDot);
          f = sealed(f);
        end
        default: ;
      endcase
      send_frame(f, (flaw == FlawShort) ? $urandom_range(1, PosCheck) : FrameLen);
      // Junk between frames; a stray sync is rare.
      repeat ($urandom_range(0, 3)) begin
        b = byte_t'($urandom);
        if (b == SyncByte && $urandom_range(0, 9) != 0) b = 8'h00;
        send_byte(b);
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned target);
    stall_on = 1'b0;
    test_random_frames(target);
  endtask

  initial begin
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    stall_on   = 1'b1;
    err_count  = 0;
    bytes_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_line_noise(60);
    test_random_frames(BytesTotal - QuietBytes);
    test_back_to_back(BytesTotal);

    rx_ch.valid <= 1'b0;
    for (int n = 0; n < DrainCycles && dist_expected.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (dist_expected.size() != 0) begin
      log_mismatch($sformatf("%0d distances never arrived", dist_expected.size()));
    end
    if (err_count == 0) begin
      $display("rangefinder_frame_parser test passed");
    end else begin
      $display("rangefinder_frame_parser test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rangefinder_frame_parser test failed");
    $finish;
  end

endmodule
